// ===== src/hapc_pkg.sv =====
// Shared types and constants of the Hall actuator position controller.
package hapc_pkg;

  localparam int MOTORS_DEF        = 5;
  localparam int POSITION_BITS_DEF = 16;

  localparam int TARGET_W  = 16;
  localparam int TOL_W     = 8;
  localparam int STALL_W   = 16;
  localparam int SCOUNT_W  = 17;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [15:0]         MAX_POSITION_RST = 16'd1000;
  localparam logic [TOL_W-1:0]    TOLERANCE_RST    = 8'd2;
  localparam logic [STALL_W-1:0]  STALL_TICKS_RST  = 16'd500;
  // A motor whose state was never written holds an idle stall timer of the
  // reset stall limit plus one.
  localparam logic [SCOUNT_W-1:0] STALL_IDLE_RST   = 17'd501;

  typedef enum logic [1:0] {
    DRV_STOP    = 2'd0,
    DRV_EXTEND  = 2'd1,
    DRV_RETRACT = 2'd2
  } drive_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_POSITION = 2'd0,
    CFG_TOLERANCE    = 2'd1,
    CFG_STALL_TICKS  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    MODE_COMMAND = 1'b0,
    MODE_TICK    = 1'b1
  } mode_t;

endpackage

// ===== src/hapc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hapc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/hall_actuator_position_controller.sv =====
// Hall actuator position controller: per-motor quadrature counting and bang-bang positioning.
// One item (command or Hall sample tick) is taken every clock while the output does not stall,
// and its result passes from the update stage into the result register. A low out_tready
// holds the result register and the update stage, and in_tready falls once both are full.
// All per-motor state (position, target, drive, stall timer and the last Hall levels) lives
// in one state RAM; each item reads its motor's entry when accepted, updates it in the update
// stage and writes it back as it leaves; a one-entry forwarding register covers an item that
// follows one for the same motor. Entries that were never written read as their reset values
// through per-motor valid bits, so no clearing pass runs after reset. Configuration is to be
// written through the cfg port while no item is in flight; the block itself does not enforce this.
module hall_actuator_position_controller
  import hapc_pkg::*;
#(
  parameter int MOTORS        = MOTORS_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input items.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata from bit 0: motor_index[2:0], stop_request, target_position[15:0], hall_a, hall_b,
  // then zero padding.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // tuser: mode.
  input  logic                  in_tuser,
  // Result items.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // tdata from bit 0: motor_id_out[2:0], drive[1:0], position[15:0], save_request,
  // then zero padding.
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]           cfg_data
);

  localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int IW = (AW > 3) ? AW : 3;
  localparam int CW = ((POSITION_BITS > TARGET_W) ? POSITION_BITS : TARGET_W) + 1;

  typedef struct packed {
    logic [POSITION_BITS-1:0] pos;
    logic [TARGET_W-1:0]      tgt;
    drive_t                   drv;
    logic [SCOUNT_W-1:0]      sc;
    logic                     la;
    logic                     lb;
  } st_t;

  localparam int ST_W = $bits(st_t);

  // Configuration registers.
  logic [15:0]        max_position_r;
  logic [TOL_W-1:0]   tolerance_r;
  logic [STALL_W-1:0] stall_ticks_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_position_r <= MAX_POSITION_RST;
      tolerance_r    <= TOLERANCE_RST;
      stall_ticks_r  <= STALL_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_POSITION: max_position_r <= cfg_data;
        CFG_TOLERANCE:    tolerance_r    <= cfg_data[TOL_W-1:0];
        CFG_STALL_TICKS:  stall_ticks_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input side.
  logic          in_acc;
  logic [2:0]    in_idx;
  logic [IW-1:0] in_idx_ext;
  logic [AW-1:0] in_addr;
  logic          in_inrange;

  assign in_acc     = in_tvalid && in_tready;
  assign in_idx     = in_tdata[2:0];
  assign in_idx_ext = IW'(in_idx);
  assign in_addr    = in_idx_ext[AW-1:0];
  assign in_inrange = 32'(in_idx) < MOTORS;

  // Update stage.
  logic                s1_valid_r;
  mode_t               s1_mode_r;
  logic [2:0]          s1_idx_r;
  logic [AW-1:0]       s1_addr_r;
  logic                s1_inrange_r;
  logic                s1_stop_r;
  logic [TARGET_W-1:0] s1_tgt_r;
  logic                s1_a_r;
  logic                s1_b_r;
  logic                s1_vld_r;
  logic                s1_adv;

  logic                fwd_valid_r;
  logic [AW-1:0]       fwd_addr_r;
  st_t                 fwd_data_r;

  logic [MOTORS-1:0]   vld_r;

  logic                out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic                wr_en;
  st_t                 cur;
  st_t                 nxt;
  logic [ST_W-1:0]     rd_data;
  logic                save;
  logic [OUT_DATA_W-1:0] res;

  assign s1_adv    = !out_tvalid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign wr_en     = s1_valid_r && s1_adv && s1_inrange_r;

  hapc_ram #(
    .WIDTH (ST_W),
    .DEPTH (MOTORS),
    .AW    (AW)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (nxt),
    .rd_en   (in_acc),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  function automatic logic [CW-1:0] step_pos(input logic [CW-1:0] p, input logic up,
                                             input logic [CW-1:0] lim);
    logic [CW-1:0] r;
    r = p;
    if (up) begin
      if (p < lim) r = p + CW'(1);
    end else begin
      if (p != '0) r = p - CW'(1);
    end
    return r;
  endfunction

  function automatic logic [15:0] p_out(input logic [POSITION_BITS-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    return w[15:0];
  endfunction

  always_comb begin
    logic [CW-1:0] lim;
    logic [CW-1:0] mp;
    logic [CW-1:0] cap;
    logic [CW-1:0] p;
    logic [CW-1:0] t;
    logic [CW-1:0] tol;
    logic [CW-1:0] ct;

    // Current state: forwarded write, RAM contents, or reset value.
    if (fwd_valid_r && fwd_addr_r == s1_addr_r) begin
      cur = fwd_data_r;
    end else if (s1_vld_r) begin
      cur = st_t'(rd_data);
    end else begin
      cur.pos = '0;
      cur.tgt = '0;
      cur.drv = DRV_STOP;
      cur.sc  = STALL_IDLE_RST;
      cur.la  = 1'b0;
      cur.lb  = 1'b0;
    end

    mp  = CW'(max_position_r);
    cap = CW'({POSITION_BITS{1'b1}});
    lim = (mp < cap) ? mp : cap;
    tol = CW'(tolerance_r);
    t   = CW'(s1_tgt_r);
    p   = CW'(cur.pos);
    ct  = CW'(cur.tgt);
    nxt  = cur;
    save = 1'b0;

    if (s1_mode_r == MODE_COMMAND) begin
      if (s1_stop_r) begin
        nxt.drv = DRV_STOP;
      end else begin
        if (s1_tgt_r == '0) begin
          nxt.drv = DRV_RETRACT;
          nxt.tgt = '0;
        end else if (s1_tgt_r == max_position_r) begin
          nxt.drv = DRV_EXTEND;
          nxt.tgt = s1_tgt_r;
        end else if (p + tol < t) begin
          nxt.drv = DRV_EXTEND;
          nxt.tgt = s1_tgt_r;
        end else if (p > t + tol) begin
          nxt.drv = DRV_RETRACT;
          nxt.tgt = s1_tgt_r;
        end
        nxt.sc = '0;
      end
    end else begin
      // Quadrature: A is evaluated first, then B against the new A level.
      if (!cur.la && s1_a_r) begin
        p = step_pos(p, !s1_b_r, lim);
        nxt.sc = '0;
      end else if (cur.la && !s1_a_r) begin
        p = step_pos(p, s1_b_r, lim);
        nxt.sc = '0;
      end
      if (!cur.lb && s1_b_r) begin
        p = step_pos(p, s1_a_r, lim);
        nxt.sc = '0;
      end else if (cur.lb && !s1_b_r) begin
        p = step_pos(p, !s1_a_r, lim);
        nxt.sc = '0;
      end
      nxt.la = s1_a_r;
      nxt.lb = s1_b_r;

      // Intermediate targets stop the drive once inside the deadband.
      if (cur.tgt != '0 && cur.tgt < max_position_r) begin
        case (cur.drv)
          DRV_RETRACT: if (p <= ct + tol) nxt.drv = DRV_STOP;
          DRV_EXTEND:  if (p + tol >= ct) nxt.drv = DRV_STOP;
          default: ;
        endcase
      end

      if (nxt.sc < SCOUNT_W'(stall_ticks_r)) begin
        nxt.sc = nxt.sc + SCOUNT_W'(1);
      end else if (nxt.sc == SCOUNT_W'(stall_ticks_r)) begin
        if (nxt.drv == DRV_RETRACT) p = '0;
        nxt.drv = DRV_STOP;
        save    = 1'b1;
        nxt.sc  = nxt.sc + SCOUNT_W'(1);
      end
      nxt.pos = p[POSITION_BITS-1:0];
    end

    res = '0;
    res[2:0] = s1_idx_r;
    if (s1_inrange_r) begin
      res[4:3]  = nxt.drv;
      res[20:5] = p_out(nxt.pos);
      res[21]   = save;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      fwd_valid_r  <= 1'b0;
      vld_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r  <= 1'b1;
        // The write of this edge is not yet visible to the read of this edge.
        fwd_valid_r <= wr_en;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (wr_en) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
      if (s1_adv) begin
        out_tvalid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r    <= mode_t'(in_tuser);
      s1_idx_r     <= in_idx;
      s1_addr_r    <= in_addr;
      s1_inrange_r <= in_inrange;
      s1_stop_r    <= in_tdata[3];
      s1_tgt_r     <= in_tdata[19:4];
      s1_a_r       <= in_tdata[20];
      s1_b_r       <= in_tdata[21];
      s1_vld_r     <= in_inrange && vld_r[in_addr];
      fwd_addr_r   <= s1_addr_r;
      fwd_data_r   <= nxt;
    end
    if (s1_adv && s1_valid_r) begin
      out_tdata_r <= res;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A result that raises a save request always reports the motor stopped.
  a_save_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tdata_r[21] |-> out_tdata_r[4:3] == DRV_STOP)
    else $error("save request with a running drive");

  // Results for motors that do not exist carry no state.
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && 32'(out_tdata_r[2:0]) >= MOTORS |-> out_tdata_r[21:3] == '0)
    else $error("out-of-range motor result carries state");

  // The state RAM is written only for items that leave the update stage.
  a_write_moves: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> out_tvalid_r)
    else $error("state written without a result");

  // A stalled update stage keeps its item.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("update stage lost an item");

endmodule
